>>> rtl/spf_pkg.sv
`default_nettype none

package spf_pkg;

   // Fixed field widths of the item formats.
   localparam int COORD_W    = 9;
   localparam int PIX_W      = 10;
   localparam int CMD_W      = 2;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;

   // Command codes carried in the request tuser.
   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_WALK,
      ST_DRAIN,
      ST_RESP
   } state_type;

   // Request payload, x_a in the lowest bits.
   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] y_b;
      logic [COORD_W-1:0] x_b;
      logic [COORD_W-1:0] y_a;
      logic [COORD_W-1:0] x_a;
   } req_fields_type;

   // Response payload, span_row in the lowest bits.
   typedef struct packed {
      logic               filled;
      logic [PIX_W-1:0]   limit_pixel;
      logic [PIX_W-1:0]   first_pixel;
      logic [COORD_W-1:0] span_row;
   } rsp_fields_type;

endpackage

`default_nettype wire

>>> rtl/spf_ram.sv
`default_nettype none

module spf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> rtl/scanline_polygon_fill_top.sv
`default_nettype none

// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tuser command, tdata x_a y_a x_b y_b row
// rsp      out        rsp_tvalid/rsp_tready  tdata span_row first_pixel limit_pixel filled
//
// A clear writes every table row empty; the same pass runs after reset, and no item
// is taken until it ends. An add-edge first runs the bit-serial slope divider (a flat
// edge skips it), then does one table read-modify-write per covered row inside the
// table. A query loads the span of its row into the response register, which holds a
// span until it is taken; only a following query waits for it.

module scanline_polygon_fill_top #(
   parameter int ROWS      = 512,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // x_a[8:0], y_a[17:9], x_b[26:18], y_b[35:27], row[44:36], zero fill.
   input  wire logic [spf_pkg::REQ_DATA_W-1:0]      req_tdata,
   // command[1:0].
   input  wire logic [spf_pkg::CMD_W-1:0]           req_tuser,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // span_row[8:0], first_pixel[18:9], limit_pixel[28:19], filled[29], zero fill.
   output logic      [spf_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   localparam int COORD_W = spf_pkg::COORD_W;
   localparam int PIX_W   = spf_pkg::PIX_W;
   localparam int AW      = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int RW      = (AW > COORD_W) ? AW : COORD_W;
   localparam int X_W     = PIX_W + FRAC_BITS;
   localparam int Q_W     = COORD_W + FRAC_BITS;
   localparam int CW      = $clog2(Q_W + 1);

   localparam logic [X_W-1:0] EMPTY_LEFT = {1'b1, {(X_W-1){1'b0}}};
   localparam logic [X_W:0]   ROUND_UP   = {{(PIX_W+1){1'b0}}, {FRAC_BITS{1'b1}}};

   spf_pkg::state_type        state_ff, state_in;
   spf_pkg::req_fields_type   req_f;
   spf_pkg::cmd_type          cmd;
   spf_pkg::rsp_fields_type   rsp_data_ff, rsp_data_in;

   logic                      req_acc;
   logic [AW-1:0]             clr_ff, clr_in;

   // Edge setup.
   logic                      swap;
   logic [COORD_W-1:0]        lo_x, lo_y, hi_x, hi_y, mag, dy;
   logic                      neg;

   // Divider and walker registers.
   logic [COORD_W-1:0]        hi_y_ff, hi_y_in;
   logic [COORD_W-1:0]        dy_ff, dy_in;
   logic                      neg_ff, neg_in;
   logic [Q_W-1:0]            dq_ff, dq_in;
   logic [COORD_W:0]          rem_ff, rem_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [COORD_W-1:0]        row_ff, row_in;
   logic [X_W-1:0]            x_ff, x_in;
   logic [COORD_W:0]          rem_sh;
   logic                      quo_bit;
   logic [X_W-1:0]            step;

   // Read-modify-write stage.
   logic                      wr_pend_ff, wr_pend_in;
   logic [AW-1:0]             wr_row_ff, wr_row_in;
   logic [X_W-1:0]            wr_x_ff, wr_x_in;

   // Query stage.
   logic                      q_oob_ff, q_oob_in;
   logic [COORD_W-1:0]        q_row_ff, q_row_in;
   logic                      rsp_tvalid_ff, rsp_tvalid_in;

   // Memory ports.
   logic                      ram_we, ram_re;
   logic [AW-1:0]             ram_waddr, ram_raddr;
   logic [2*X_W-1:0]          ram_wdata, ram_rdata;
   logic [X_W-1:0]            cur_l, cur_r, new_l, new_r, q_l, q_r;
   logic [X_W:0]              q_sum;
   logic                      walk_rd, query_rd;

   // True when a row lies inside the table.
   function automatic logic in_table(input logic [COORD_W-1:0] r);
      logic [RW:0] ext;
      ext = (RW+1)'(r);
      return ext < (RW+1)'(ROWS);
   endfunction

   // Table address of a row.
   function automatic logic [AW-1:0] row_addr(input logic [COORD_W-1:0] r);
      logic [RW-1:0] ext;
      ext = RW'(r);
      return ext[AW-1:0];
   endfunction

   assign req_f   = spf_pkg::req_fields_type'(req_tdata[5*COORD_W-1:0]);
   assign cmd     = spf_pkg::cmd_type'(req_tuser);
   assign req_acc = req_tvalid && req_tready;

   // Order the endpoints by y and form the slope magnitude inputs.
   always_comb begin
      swap = req_f.y_b < req_f.y_a;
      lo_x = swap ? req_f.x_b : req_f.x_a;
      lo_y = swap ? req_f.y_b : req_f.y_a;
      hi_x = swap ? req_f.x_a : req_f.x_b;
      hi_y = swap ? req_f.y_a : req_f.y_b;
      neg  = hi_x < lo_x;
      mag  = neg ? (lo_x - hi_x) : (hi_x - lo_x);
      dy   = hi_y - lo_y;
   end

   // One restoring division step per cycle.
   always_comb begin
      rem_sh  = {rem_ff[COORD_W-1:0], dq_ff[Q_W-1]};
      quo_bit = rem_sh >= {1'b0, dy_ff};
      step    = X_W'(dq_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         spf_pkg::ST_CLEAR: begin
            if (clr_ff == AW'(ROWS - 1)) begin
               state_in = spf_pkg::ST_IDLE;
            end
         end
         spf_pkg::ST_IDLE: begin
            if (req_acc) begin
               case (cmd)
                  spf_pkg::CMD_CLEAR: state_in = spf_pkg::ST_CLEAR;
                  spf_pkg::CMD_ADD: begin
                     state_in = (dy == '0) ? spf_pkg::ST_WALK : spf_pkg::ST_DIV;
                  end
                  spf_pkg::CMD_QUERY: state_in = spf_pkg::ST_RESP;
                  default:            state_in = spf_pkg::ST_IDLE;
               endcase
            end
         end
         spf_pkg::ST_DIV: begin
            if (cnt_ff == CW'(Q_W - 1)) begin
               state_in = spf_pkg::ST_WALK;
            end
         end
         spf_pkg::ST_WALK: begin
            if (row_ff == hi_y_ff) begin
               state_in = spf_pkg::ST_DRAIN;
            end
         end
         spf_pkg::ST_DRAIN: state_in = spf_pkg::ST_IDLE;
         spf_pkg::ST_RESP: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               state_in = spf_pkg::ST_IDLE;
            end
         end
         default: state_in = spf_pkg::ST_IDLE;
      endcase
   end

   // Controller outputs.
   always_comb begin
      req_tready = state_ff == spf_pkg::ST_IDLE;
      walk_rd    = (state_ff == spf_pkg::ST_WALK) && in_table(row_ff);
      query_rd   = req_acc && (cmd == spf_pkg::CMD_QUERY) && in_table(req_f.row);
   end

   // Memory read, merge and write.
   always_comb begin
      cur_l     = ram_rdata[X_W-1:0];
      cur_r     = ram_rdata[2*X_W-1:X_W];
      new_l     = (wr_x_ff < cur_l) ? wr_x_ff : cur_l;
      new_r     = (wr_x_ff > cur_r) ? wr_x_ff : cur_r;
      ram_re    = walk_rd || query_rd;
      ram_raddr = walk_rd ? row_addr(row_ff) : row_addr(req_f.row);
      if (state_ff == spf_pkg::ST_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = {{X_W{1'b0}}, EMPTY_LEFT};
      end else begin
         ram_we    = wr_pend_ff;
         ram_waddr = wr_row_ff;
         ram_wdata = {new_r, new_l};
      end
   end

   // Span of the queried row.
   always_comb begin
      q_l   = q_oob_ff ? EMPTY_LEFT : cur_l;
      q_r   = q_oob_ff ? '0 : cur_r;
      q_sum = {1'b0, q_r} + ROUND_UP;
      rsp_data_in             = rsp_data_ff;
      rsp_data_in.span_row    = q_row_ff;
      rsp_data_in.first_pixel = q_l[X_W-1:FRAC_BITS];
      rsp_data_in.limit_pixel = q_sum[X_W-1:FRAC_BITS];
      rsp_data_in.filled      = q_l <= q_r;
      if (!((state_ff == spf_pkg::ST_RESP) && (!rsp_tvalid_ff || rsp_tready))) begin
         rsp_data_in = rsp_data_ff;
      end
   end

   // Output valid.
   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if ((state_ff == spf_pkg::ST_RESP) && (!rsp_tvalid_ff || rsp_tready)) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   // Datapath next values.
   always_comb begin
      clr_in     = clr_ff;
      hi_y_in    = hi_y_ff;
      dy_in      = dy_ff;
      neg_in     = neg_ff;
      dq_in      = dq_ff;
      rem_in     = rem_ff;
      cnt_in     = cnt_ff;
      row_in     = row_ff;
      x_in       = x_ff;
      q_oob_in   = q_oob_ff;
      q_row_in   = q_row_ff;
      wr_pend_in = walk_rd;
      wr_row_in  = row_addr(row_ff);
      wr_x_in    = x_ff;
      case (state_ff)
         spf_pkg::ST_CLEAR: clr_in = clr_ff + AW'(1);
         spf_pkg::ST_IDLE: begin
            clr_in = '0;
            if (req_acc && (cmd == spf_pkg::CMD_ADD)) begin
               hi_y_in = hi_y;
               dy_in   = dy;
               neg_in  = neg;
               dq_in   = {mag, {FRAC_BITS{1'b0}}};
               rem_in  = '0;
               cnt_in  = '0;
               row_in  = lo_y;
               x_in    = {1'b0, lo_x, {FRAC_BITS{1'b0}}};
            end
            if (req_acc && (cmd == spf_pkg::CMD_QUERY)) begin
               q_oob_in = !in_table(req_f.row);
               q_row_in = req_f.row;
            end
         end
         spf_pkg::ST_DIV: begin
            rem_in = quo_bit ? (rem_sh - {1'b0, dy_ff}) : rem_sh;
            dq_in  = {dq_ff[Q_W-2:0], quo_bit};
            cnt_in = cnt_ff + CW'(1);
         end
         spf_pkg::ST_WALK: begin
            row_in = row_ff + COORD_W'(1);
            x_in   = neg_ff ? (x_ff - step) : (x_ff + step);
         end
         default: begin
         end
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= spf_pkg::ST_CLEAR;
         clr_ff        <= '0;
         wr_pend_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         wr_pend_ff    <= wr_pend_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      hi_y_ff     <= hi_y_in;
      dy_ff       <= dy_in;
      neg_ff      <= neg_in;
      dq_ff       <= dq_in;
      rem_ff      <= rem_in;
      cnt_ff      <= cnt_in;
      row_ff      <= row_in;
      x_ff        <= x_in;
      wr_row_ff   <= wr_row_in;
      wr_x_ff     <= wr_x_in;
      q_oob_ff    <= q_oob_in;
      q_row_ff    <= q_row_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Left edge in the low half of each entry, right edge in the high half.
   spf_ram #(
      .WIDTH (2 * X_W),
      .DEPTH (ROWS)
   ) u_edge_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(spf_pkg::RSP_DATA_W - $bits(rsp_data_ff)){1'b0}}, rsp_data_ff};

endmodule

`default_nettype wire

>>> rtl/spf_checker.sv
`default_nettype none

module spf_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic [spf_pkg::CMD_W-1:0]      req_tuser,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [spf_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // A stalled span holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled span changed");

   // The table sweep after reset blocks new items.
   assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("item taken during table sweep");

   // A clear or an add-edge keeps the block busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready &&
      (req_tuser == spf_pkg::CMD_CLEAR || req_tuser == spf_pkg::CMD_ADD) |=> !req_tready)
      else $error("no busy cycle after clear or add");

   // A fresh span appears only out of a busy cycle.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tready))
      else $error("span raised while idle");

   // A filled span never starts past its limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[29] |-> rsp_tdata[18:9] <= rsp_tdata[28:19])
      else $error("filled span with first pixel past limit");

endmodule

bind scanline_polygon_fill_top spf_checker u_spf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
